FILE: rtl/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg: shared types and constants of the kinetic scroll engine
// Event codes, register map, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package kse_pkg;

    // field widths
    localparam int POS_W  = 16;
    localparam int TIME_W = 32;
    localparam int VEL_W  = 32;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // serial divider / multiplier: one bit per cycle
    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS);

    // tick distance clamp, raw value 2^62 in Q48.16
    localparam logic [63:0] DIST_CLAMP = 64'h4000_0000_0000_0000;
    localparam logic [31:0] VEL_MAX    = 32'h7FFF_FFFF;

    // register reset values
    localparam logic [15:0] STILL_RST    = 16'd100;
    localparam logic [7:0]  DEAD_RST     = 8'd12;
    localparam logic [3:0]  FRICTION_RST = 4'd1;

    typedef enum logic [2:0] {
        OP_PRESS   = 3'd0,
        OP_DRAG    = 3'd1,
        OP_RELEASE = 3'd2,
        OP_STOP    = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        REG_STILL    = 2'd0,
        REG_DEAD     = 2'd1,
        REG_FRICTION = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_POST1,
        ST_POST2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] still;
        logic [7:0]  dead;
        logic [3:0]  fshift;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;   // capture the input transfer
        logic load;    // load the serial units
        logic div;     // divide (release) rather than multiply (tick)
        logic step;    // one divide or multiply step
        logic post1;   // clamp and sign the product
        logic post2;   // subtract the distance already travelled
        logic commit;  // update state and load the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic refuse;
        logic running;
    } dp_stat_t;

endpackage

FILE: rtl/kse_lane.sv
// ----------------------------------------------------------------------------
// kse_lane: one axis of the arithmetic
// Shared radix-2 unit: restoring divide for the release velocity, shift-add
// multiply for the tick distance, then clamp, subtract and round.
// ----------------------------------------------------------------------------
module kse_lane (
    input  logic               clk,
    input  kse_pkg::dp_cmd_t   cmd,
    input  logic [31:0]        load_val,  // dividend or multiplier
    input  logic [31:0]        opd,       // divisor or multiplicand
    input  logic               neg,       // sign of the result
    input  logic [31:0]        trav,      // distance travelled, signed
    input  logic [3:0]         fshift,
    output logic [31:0]        vel,
    output logic [15:0]        delta
);
    import kse_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] opd_reg;
    logic        neg_reg;
    logic        div_reg;

    logic [32:0] sh;
    logic [33:0] trial;
    logic [32:0] sum;
    logic [63:0] prod;
    logic [63:0] pc;
    logic [63:0] pneg;
    logic [63:0] tsh;
    logic [63:0] diff;
    logic [47:0] q48;
    logic [31:0] qs;
    logic [31:0] mag;

    // step and post-processing datapath
    always_comb
    begin
        sh    = {rem_reg, q_reg[31]};
        trial = {1'b0, sh} - {2'b00, opd_reg};
        sum   = {1'b0, rem_reg} + (q_reg[0] ? {1'b0, opd_reg} : 33'd0);
        prod  = {rem_reg, q_reg};
        pc    = (prod > DIST_CLAMP) ? DIST_CLAMP : prod;
        pneg  = neg_reg ? (64'd0 - pc) : pc;
        tsh   = {{16{trav[31]}}, trav, 16'd0};
        diff  = prod - tsh;

        rem_next = rem_reg;
        q_next   = q_reg;
        if (cmd.load)
        begin
            rem_next = '0;
            q_next   = load_val;
        end
        else if (cmd.step)
        begin
            if (div_reg)
            begin
                if (!trial[33])
                begin
                    rem_next = trial[31:0];
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = sh[31:0];
                    q_next   = {q_reg[30:0], 1'b0};
                end
            end
            else
            begin
                rem_next = sum[32:1];
                q_next   = {sum[0], q_reg[31:1]};
            end
        end
        else if (cmd.post1)
        begin
            {rem_next, q_next} = pneg;
        end
        else if (cmd.post2)
        begin
            {rem_next, q_next} = diff;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (cmd.load)
        begin
            opd_reg <= opd;
            neg_reg <= neg;
            div_reg <= cmd.div;
        end
    end

    // velocity: friction shift, saturate, apply sign
    always_comb
    begin
        qs  = q_reg >> fshift;
        mag = qs[31] ? VEL_MAX : qs;
        vel = neg_reg ? (32'd0 - mag) : mag;
    end

    // delta: divide by 2^16 toward zero, saturate to 16 bits
    always_comb
    begin
        q48 = prod[63:16] + {47'd0, prod[63] & (|prod[15:0])};
        if (!q48[47] && (|q48[46:15]))
            delta = 16'h7FFF;
        else if (q48[47] && !(&q48[46:15]))
            delta = 16'h8000;
        else
            delta = q48[15:0];
    end

endmodule

FILE: rtl/kse_dp.sv
// ----------------------------------------------------------------------------
// kse_dp: datapath of the kinetic scroll engine
// Input capture, gesture marks, velocity and travel state, the two axis
// lanes and the output payload register.
// ----------------------------------------------------------------------------
module kse_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  kse_pkg::dp_cmd_t    cmd,
    input  kse_pkg::cfg_t       cfg,
    input  logic [2:0]          in_op,
    input  logic signed [15:0]  in_x,
    input  logic signed [15:0]  in_y,
    input  logic [31:0]         in_stamp,
    output kse_pkg::dp_stat_t   stat,
    output logic                out_apply,
    output logic signed [15:0]  out_dx,
    output logic signed [15:0]  out_dy,
    output logic                out_active,
    output logic                out_was_on
);
    import kse_pkg::*;

    // captured event
    op_t         op_reg;
    logic [15:0] x_reg, y_reg;
    logic [31:0] t_reg;

    // gesture state
    logic [15:0] press_x_reg, press_y_reg, drag_x_reg, drag_y_reg;
    logic [31:0] press_time_reg, drag_time_reg, release_time_reg;
    logic [31:0] vel_x_reg, vel_y_reg, trav_x_reg, trav_y_reg;
    logic        running_reg;
    logic        run_next;

    logic [31:0] rest, el_press, el_rel, divisor;
    logic [16:0] rdx, rdy, pdx, pdy;
    logic [15:0] mag_px, mag_py;
    logic        in_zone_x, in_zone_y, refuse;
    logic [31:0] vabs_x, vabs_y;
    logic [31:0] ld_x, ld_y, opd_x, opd_y;
    logic        neg_x, neg_y;
    logic [31:0] lane_vel_x, lane_vel_y;
    logic [15:0] lane_dx, lane_dy;
    logic        do_tick;

    function automatic logic [15:0] mag17(input logic [16:0] d);
        logic [16:0] n;
        n = d[16] ? (17'd0 - d) : d;
        return n[15:0];
    endfunction

    // capture the input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= op_t'(in_op);
            x_reg  <= in_x;
            y_reg  <= in_y;
            t_reg  <= in_stamp;
        end
    end

    // release decision and serial unit operands
    always_comb
    begin
        rest      = t_reg - drag_time_reg;
        rdx       = {x_reg[15], x_reg} - {drag_x_reg[15], drag_x_reg};
        rdy       = {y_reg[15], y_reg} - {drag_y_reg[15], drag_y_reg};
        in_zone_x = mag17(rdx) < {8'd0, cfg.dead};
        in_zone_y = mag17(rdy) < {8'd0, cfg.dead};
        refuse    = (rest > {16'd0, cfg.still}) && in_zone_x && in_zone_y;

        el_press  = t_reg - press_time_reg;
        divisor   = (el_press == 32'd0) ? 32'd1 : el_press;
        pdx       = {x_reg[15], x_reg} - {press_x_reg[15], press_x_reg};
        pdy       = {y_reg[15], y_reg} - {press_y_reg[15], press_y_reg};
        mag_px    = mag17(pdx);
        mag_py    = mag17(pdy);

        el_rel    = t_reg - release_time_reg;
        vabs_x    = vel_x_reg[31] ? (32'd0 - vel_x_reg) : vel_x_reg;
        vabs_y    = vel_y_reg[31] ? (32'd0 - vel_y_reg) : vel_y_reg;

        ld_x  = cmd.div ? {mag_px, 16'd0} : el_rel;
        ld_y  = cmd.div ? {mag_py, 16'd0} : el_rel;
        opd_x = cmd.div ? divisor : vabs_x;
        opd_y = cmd.div ? divisor : vabs_y;
        neg_x = cmd.div ? pdx[16] : vel_x_reg[31];
        neg_y = cmd.div ? pdy[16] : vel_y_reg[31];
    end

    assign stat.op      = op_reg;
    assign stat.refuse  = refuse;
    assign stat.running = running_reg;

    kse_lane u_lane_x (
        .clk      (clk),
        .cmd      (cmd),
        .load_val (ld_x),
        .opd      (opd_x),
        .neg      (neg_x),
        .trav     (trav_x_reg),
        .fshift   (cfg.fshift),
        .vel      (lane_vel_x),
        .delta    (lane_dx)
    );

    kse_lane u_lane_y (
        .clk      (clk),
        .cmd      (cmd),
        .load_val (ld_y),
        .opd      (opd_y),
        .neg      (neg_y),
        .trav     (trav_y_reg),
        .fshift   (cfg.fshift),
        .vel      (lane_vel_y),
        .delta    (lane_dy)
    );

    // running flag after this event
    always_comb
    begin
        run_next = running_reg;
        unique case (op_reg)
            OP_RELEASE: run_next = !refuse;
            OP_STOP:    run_next = 1'b0;
            default:    run_next = running_reg;
        endcase
        do_tick = (op_reg == OP_TICK) && running_reg;
    end

    // state update on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_x_reg      <= '0;
            press_y_reg      <= '0;
            press_time_reg   <= '0;
            drag_x_reg       <= '0;
            drag_y_reg       <= '0;
            drag_time_reg    <= '0;
            release_time_reg <= '0;
            vel_x_reg        <= '0;
            vel_y_reg        <= '0;
            trav_x_reg       <= '0;
            trav_y_reg       <= '0;
            running_reg      <= 1'b0;
        end
        else if (cmd.commit)
        begin
            running_reg <= run_next;
            unique case (op_reg)
                OP_PRESS:
                begin
                    press_x_reg    <= x_reg;
                    press_y_reg    <= y_reg;
                    press_time_reg <= t_reg;
                end
                OP_DRAG:
                begin
                    drag_x_reg    <= x_reg;
                    drag_y_reg    <= y_reg;
                    drag_time_reg <= t_reg;
                end
                OP_RELEASE:
                begin
                    release_time_reg <= t_reg;
                    if (!refuse)
                    begin
                        vel_x_reg  <= lane_vel_x;
                        vel_y_reg  <= lane_vel_y;
                        trav_x_reg <= '0;
                        trav_y_reg <= '0;
                    end
                end
                OP_TICK:
                begin
                    if (running_reg)
                    begin
                        trav_x_reg <= trav_x_reg + {{16{lane_dx[15]}}, lane_dx};
                        trav_y_reg <= trav_y_reg + {{16{lane_dy[15]}}, lane_dy};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_apply  <= do_tick;
            out_dx     <= do_tick ? lane_dx : 16'd0;
            out_dy     <= do_tick ? lane_dy : 16'd0;
            out_active <= run_next;
            out_was_on <= (op_reg == OP_STOP) && running_reg;
        end
    end

endmodule

FILE: rtl/kse_ctrl.sv
// ----------------------------------------------------------------------------
// kse_ctrl: controller of the kinetic scroll engine
// Sequences capture, divide/multiply steps, post-processing and commit,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module kse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  kse_pkg::dp_stat_t  stat,
    output kse_pkg::dp_cmd_t   cmd
);
    import kse_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic             valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            div_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            div_reg   <= div_next;
            valid_reg <= valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        valid_next = m_tready ? 1'b0 : valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cnt_next = '0;
                if (stat.op == OP_RELEASE && !stat.refuse)
                begin
                    cmd.load   = 1'b1;
                    cmd.div    = 1'b1;
                    div_next   = 1'b1;
                    state_next = ST_ITER;
                end
                else if (stat.op == OP_TICK && stat.running)
                begin
                    cmd.load   = 1'b1;
                    div_next   = 1'b0;
                    state_next = ST_ITER;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ITER:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                    state_next = div_reg ? ST_DONE : ST_POST1;
            end
            ST_POST1:
            begin
                cmd.post1  = 1'b1;
                state_next = ST_POST2;
            end
            ST_POST2:
            begin
                cmd.post2  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

endmodule

FILE: rtl/kinetic_scroll_engine.sv
// ----------------------------------------------------------------------------
// kinetic_scroll_engine: fling scrolling from pointer events
// Top level: register port, controller, datapath and stream packing.
// ----------------------------------------------------------------------------
// Usage:
//   Pointer events enter on the s_ stream (s_tuser = event code, s_tdata =
//   position and millisecond stamp). Each event yields exactly one result
//   transfer on the m_ stream (m_tuser = apply, m_tdata = deltas and flags).
//   Flow: press, drag, stop, unused codes and a tick while idle go from the
//   capture through the prepare state straight to the commit. A release that
//   starts a fling runs the 32-step serial divider; a tick while the fling
//   runs uses the 32-step serial multiplier plus clamp and subtract.
//   One event is in work at a time; the input reopens the cycle after the
//   commit, even if the receiver has not taken the previous result yet. A
//   stalled receiver holds the result and stops the engine at the commit of
//   the following event. Reset clears all gesture state (not scrolling) and
//   loads the register defaults: still time 100 ms, dead zone 12 px,
//   friction shift 1. The user must write the registers over the APB-style
//   port only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module kinetic_scroll_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    // input events
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // pos_x[15:0], pos_y[31:16], stamp_ms[63:32]
    input  logic [2:0]                  s_tuser,   // op[2:0]
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // delta_x[15:0], delta_y[31:16], active[32],
                                                   // was_on[33], zero[39:34]
    output logic                        m_tuser,   // apply[0]
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kse_pkg::ADDR_W-1:0]  paddr,
    input  logic [kse_pkg::DATA_W-1:0]  pwdata,
    output logic [kse_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import kse_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    reg_idx_t    reg_sel;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        out_apply, out_active, out_was_on;
    logic [15:0] out_dx, out_dy;

    // register writes
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.still  <= STILL_RST;
            cfg_reg.dead   <= DEAD_RST;
            cfg_reg.fshift <= FRICTION_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_STILL:    cfg_reg.still  <= pwdata[15:0];
                REG_DEAD:     cfg_reg.dead   <= pwdata[7:0];
                REG_FRICTION: cfg_reg.fshift <= pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_STILL:    prdata = {16'd0, cfg_reg.still};
            REG_DEAD:     prdata = {24'd0, cfg_reg.dead};
            REG_FRICTION: prdata = {28'd0, cfg_reg.fshift};
            default:      prdata = '0;
        endcase
    end

    kse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kse_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .in_op      (s_tuser),
        .in_x       (s_tdata[15:0]),
        .in_y       (s_tdata[31:16]),
        .in_stamp   (s_tdata[63:32]),
        .stat       (stat),
        .out_apply  (out_apply),
        .out_dx     (out_dx),
        .out_dy     (out_dy),
        .out_active (out_active),
        .out_was_on (out_was_on)
    );

    // result packing
    assign m_tdata = {6'd0, out_was_on, out_active, out_dy, out_dx};
    assign m_tuser = out_apply;

    // a tick only applies deltas while the fling runs
    a_apply_active: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[32])
        else $error("apply without active fling");

    // deltas are zero unless applied
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonzero delta without apply");

    // a stop always leaves the fling halted
    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[33] && m_tdata[32]))
        else $error("was_on with active still set");

    // one event at a time: input closes after a transfer
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second input transfer while busy");

endmodule
